@@ design/scdv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer package
// Shared types, constants and the repetition vote used by the deframer.
// ----------------------------------------------------------------------------
package scdv_pkg;

    // Frame and protocol constants.
    localparam logic [7:0] C_SYNC_BYTE = 8'hAA;
    localparam int         C_ID_REGS   = 4;
    localparam int         C_MAX_IDS   = 4;
    localparam logic [1:0] C_LAST_SEQ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] C_REG_ID_COUNT = 3'd0;
    localparam logic [2:0] C_REG_ID_A     = 3'd1;
    localparam logic [2:0] C_REG_ID_B     = 3'd2;
    localparam logic [2:0] C_REG_ID_C     = 3'd3;
    localparam logic [2:0] C_REG_ID_D     = 3'd4;

    // A complete frame found by the window.
    typedef struct packed {
        logic       hit;
        logic [7:0] id_seq;
        logic [7:0] data;
    } t_frame;

    // Accepted-id configuration.
    typedef struct packed {
        logic [2:0]                  id_count;
        logic [C_ID_REGS-1:0][4:0]   ids;
    } t_cfg;

    // One finished datagram.
    typedef struct packed {
        logic       valid;
        logic [4:0] target_id;
        logic [7:0] voted_data;
        logic [2:0] vote_mask;
    } t_result;

    // Repetition vote over the three copies.
    function automatic logic [7:0] f_vote(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [2:0] seen);
        logic [7:0] v;
        if (seen == 3'b111) begin
            if (a == b) begin
                v = a;
            end else if (b == c) begin
                v = b;
            end else begin
                v = a;
            end
        end else if (seen[0]) begin
            v = a;
        end else if (seen[1]) begin
            v = b;
        end else if (seen[2]) begin
            v = c;
        end else begin
            v = 8'd0;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/sync_checksum_deframer_with_vote_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Repeated-frame deframer with repetition vote
// The block takes one received word per clock cycle unless the input side
// stalls. Each word is registered, then passes through the frame window and
// the copy collector into the result register, which shows the result of the
// word that finishes a datagram. The input side stalls only when a word would
// finish a datagram while the result register still holds an untaken result.
// Configuration is written through the plain write port while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
// Index 0 is the number of ids in use and indexes 1 to 4 are the accepted ids.
// ----------------------------------------------------------------------------
module sync_checksum_deframer_with_vote_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [4:0]      o_target_id,
    output logic [7:0]      o_voted_data,
    output logic [2:0]      o_vote_mask
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [4:0]         r_target_id;
    logic [7:0]         r_voted_data;
    logic [2:0]         r_vote_mask;
    scdv_pkg::t_cfg     r_cfg;
    scdv_pkg::t_frame   frame;
    scdv_pkg::t_result  result;
    logic               out_free;
    logic               adv;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scdv_pkg::C_REG_ID_COUNT: r_cfg.id_count <= i_cfg_data[2:0];
                scdv_pkg::C_REG_ID_A:     r_cfg.ids[0]   <= i_cfg_data;
                scdv_pkg::C_REG_ID_B:     r_cfg.ids[1]   <= i_cfg_data;
                scdv_pkg::C_REG_ID_C:     r_cfg.ids[2]   <= i_cfg_data;
                scdv_pkg::C_REG_ID_D:     r_cfg.ids[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The registered word advances unless its result has nowhere to go.
    assign out_free = !r_out_valid || i_ready;
    assign adv      = r_in_valid && (!result.valid || out_free);
    assign o_ready  = !r_in_valid || adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scdv_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_frame (frame)
    );

    scdv_collect u_collect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_frame  (frame),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.valid) begin
            r_target_id  <= result.target_id;
            r_voted_data <= result.voted_data;
            r_vote_mask  <= result.vote_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_target_id  = r_target_id;
    assign o_voted_data = r_voted_data;
    assign o_vote_mask  = r_vote_mask;

    // A finished datagram is always shown on the next cycle.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && result.valid) |=> o_valid)
        else $error("finished datagram not loaded into result register");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(adv && result.valid))
        else $error("waiting result overwritten");

    // A shown result always carries a nonzero id.
    a_out_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_target_id != 5'd0))
        else $error("result with zero id");

endmodule
`default_nettype wire

@@ design/scdv_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame window
// Holds the last three bytes and detects a sync, id/seq, data, check frame.
// ----------------------------------------------------------------------------
module scdv_window (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic [7:0]     i_byte,
    output scdv_pkg::t_frame    o_frame
);

    logic [7:0] r_w0, r_w1, r_w2;
    logic [1:0] r_fill;
    logic       full;

    // A frame is complete when the window is full, starts with sync and
    // the new byte matches the check.
    assign full = (r_fill == 2'd3);
    assign o_frame.hit    = full && (r_w0 == scdv_pkg::C_SYNC_BYTE)
                            && ((r_w1 ^ r_w2) == i_byte);
    assign o_frame.id_seq = r_w1;
    assign o_frame.data   = r_w2;

    // Fill count: grows to three, clears on a good frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_adv) begin
            if (!full) begin
                r_fill <= r_fill + 2'd1;
            end else if (o_frame.hit) begin
                r_fill <= 2'd0;
            end
        end
    end

    // Window bytes: fill in place, shift by one byte on a bad window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= 8'd0;
            r_w1 <= 8'd0;
            r_w2 <= 8'd0;
        end else if (i_adv) begin
            if (!full) begin
                case (r_fill)
                    2'd0:    r_w0 <= i_byte;
                    2'd1:    r_w1 <= i_byte;
                    default: r_w2 <= i_byte;
                endcase
            end else if (!o_frame.hit) begin
                r_w0 <= r_w1;
                r_w1 <= r_w2;
                r_w2 <= i_byte;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/scdv_collect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Copy collector
// Locks on an accepted id, gathers copies with rising seq and votes.
// ----------------------------------------------------------------------------
module scdv_collect (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire scdv_pkg::t_frame    i_frame,
    input  wire scdv_pkg::t_cfg      i_cfg,
    output scdv_pkg::t_result        o_result
);

    logic       r_collecting;
    logic [1:0] r_exp_seq;
    logic [4:0] r_locked_id;
    logic [7:0] r_va, r_vb, r_vc;
    logic [2:0] r_seen;

    logic       n_collecting;
    logic [1:0] n_exp_seq;
    logic [4:0] n_locked_id;
    logic [7:0] n_va, n_vb, n_vc;
    logic [2:0] n_seen;

    logic [4:0] id;
    logic [2:0] seq;
    logic [2:0] limit;
    logic       match;
    logic       active;
    logic [4:0] lid;
    logic [1:0] es;
    logic       take;
    logic       cont;
    logic [7:0] va, vb, vc;
    logic [2:0] seen;

    assign id  = i_frame.id_seq[7:3];
    assign seq = i_frame.id_seq[2:0];

    // Id match against the first id_count registers, at most four; id 0 never matches.
    always_comb begin
        limit = i_cfg.id_count;
        if (limit > 3'(scdv_pkg::C_MAX_IDS)) begin
            limit = 3'(scdv_pkg::C_MAX_IDS);
        end
        match = 1'b0;
        for (int k = 0; k < scdv_pkg::C_ID_REGS; k++) begin
            if ((3'(k) < limit) && (i_cfg.ids[k] == id)) begin
                match = 1'b1;
            end
        end
        if (id == 5'd0) begin
            match = 1'b0;
        end
    end

    // Frame handling: start, store a copy, or finish the datagram.
    always_comb begin
        active = i_frame.hit && (r_collecting || match);
        lid    = r_collecting ? r_locked_id : id;
        es     = r_collecting ? r_exp_seq : 2'd0;
        va     = r_collecting ? r_va : 8'd0;
        vb     = r_collecting ? r_vb : 8'd0;
        vc     = r_collecting ? r_vc : 8'd0;
        seen   = r_collecting ? r_seen : 3'd0;
        take   = (id == lid) && (seq >= {1'b0, es}) && (seq <= {1'b0, scdv_pkg::C_LAST_SEQ});
        if (take) begin
            case (seq[1:0])
                2'd0:    va = i_frame.data;
                2'd1:    vb = i_frame.data;
                default: vc = i_frame.data;
            endcase
            seen = seen | (3'b001 << seq[1:0]);
        end
        cont = take && (seq[1:0] != scdv_pkg::C_LAST_SEQ);

        o_result.valid      = active && !cont;
        o_result.target_id  = lid;
        o_result.voted_data = scdv_pkg::f_vote(va, vb, vc, seen);
        o_result.vote_mask  = seen;

        n_collecting = r_collecting;
        n_exp_seq    = r_exp_seq;
        n_locked_id  = r_locked_id;
        n_va         = r_va;
        n_vb         = r_vb;
        n_vc         = r_vc;
        n_seen       = r_seen;
        if (active) begin
            if (cont) begin
                n_collecting = 1'b1;
                n_exp_seq    = seq[1:0] + 2'd1;
                n_locked_id  = lid;
                n_va         = va;
                n_vb         = vb;
                n_vc         = vc;
                n_seen       = seen;
            end else begin
                n_collecting = 1'b0;
                n_exp_seq    = 2'd0;
                n_locked_id  = 5'd0;
                n_va         = 8'd0;
                n_vb         = 8'd0;
                n_vc         = 8'd0;
                n_seen       = 3'd0;
            end
        end
    end

    // Collector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_exp_seq    <= 2'd0;
            r_locked_id  <= 5'd0;
            r_va         <= 8'd0;
            r_vb         <= 8'd0;
            r_vc         <= 8'd0;
            r_seen       <= 3'd0;
        end else if (i_adv) begin
            r_collecting <= n_collecting;
            r_exp_seq    <= n_exp_seq;
            r_locked_id  <= n_locked_id;
            r_va         <= n_va;
            r_vb         <= n_vb;
            r_vc         <= n_vc;
            r_seen       <= n_seen;
        end
    end

    // A locked datagram always has a nonzero id.
    a_locked_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_locked_id != 5'd0))
        else $error("collecting with zero locked id");

    // While collecting, the next expected copy is seq 1 or seq 2.
    a_exp_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> ((r_exp_seq == 2'd1) || (r_exp_seq == 2'd2)))
        else $error("bad expected sequence while collecting");

    // The received copies always fall below the expected sequence.
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> ((r_seen != 3'd0) && (r_seen[2] == 1'b0)))
        else $error("copy mask inconsistent with collecting state");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_collecting |-> (r_seen == 3'd0))
        else $error("copy mask not cleared while searching");

endmodule
`default_nettype wire
